/* rtl/atd_pkg.sv */
// Shared types, constants and helper functions for the ASCII telegram deframer.
// Used by atd_front, atd_queue, atd_back and ascii_telegram_deframer.
// No dependencies.
package atd_pkg;

   // Telegram layout and limits.
   localparam logic [6:0] MAX_PAYLOAD    = 7'd99;
   localparam logic [7:0] MIN_FRAME      = 8'd13;
   localparam logic [6:0] POSITION_LIMIT = 7'd127;
   localparam logic [6:0] DATA_START     = 7'd10;
   localparam logic [6:0] WINDOW_LEN     = 7'd6;

   // Byte positions of the header fields.
   localparam logic [6:0] POS_ADDR_LAST  = 7'd2;
   localparam logic [6:0] POS_ACTION     = 7'd3;
   localparam logic [6:0] POS_PARAM_FIRST = 7'd5;
   localparam logic [6:0] POS_PARAM_LAST = 7'd7;
   localparam logic [6:0] POS_LEN_HIGH   = 7'd8;
   localparam logic [6:0] POS_LEN_LOW    = 7'd9;

   // Six-byte payload codes.
   localparam logic [47:0] CODE_NODEF = 48'h4E4F5F444546;
   localparam logic [47:0] CODE_RANGE = 48'h5F52414E4745;
   localparam logic [47:0] CODE_LOGIC = 48'h5F4C4F474943;

   // Result kinds.
   localparam logic KIND_PAYLOAD = 1'b0;
   localparam logic KIND_STATUS  = 1'b1;

   // Status codes.
   localparam logic [2:0] STATUS_OK    = 3'd0;
   localparam logic [2:0] STATUS_FRAME = 3'd1;
   localparam logic [2:0] STATUS_NODEF = 3'd2;
   localparam logic [2:0] STATUS_RANGE = 3'd3;
   localparam logic [2:0] STATUS_LOGIC = 3'd4;

   // Depth of the queue between front and back.
   localparam int QUEUE_DEPTH = 2;

   // One classified transfer handed from the front to the back.
   typedef struct packed {
      logic        kind;
      logic [7:0]  data_byte;
      logic [6:0]  index;
      logic [23:0] address;
      logic [7:0]  action;
      logic [23:0] parameter_chars;
      logic [6:0]  length_value;
      logic        length_bad;
      logic [7:0]  frame_len;
      logic [23:0] trailing;
      logic [7:0]  sum;
      logic [47:0] window;
   } entry_type;

   // True for an ASCII decimal digit.
   function automatic logic is_digit(input logic [7:0] c);
      return (c >= 8'h30) && (c <= 8'h39);
   endfunction

   // Value of an ASCII digit (valid only when is_digit holds).
   function automatic logic [3:0] digit_value(input logic [7:0] c);
      logic [7:0] d;
      d = c - 8'h30;
      return d[3:0];
   endfunction

endpackage

/* rtl/atd_front.sv */
// Front end of the deframer: accepts bytes, tracks the telegram fields and
// decides which bytes produce a result. Depends on atd_pkg.
module atd_front #(
   parameter logic [6:0] MAX_PAYLOAD    = atd_pkg::MAX_PAYLOAD,
   parameter logic [6:0] POSITION_LIMIT = atd_pkg::POSITION_LIMIT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [7:0]         req_rx_byte,
   input  logic               req_final_byte,
   output logic               push,
   output atd_pkg::entry_type push_entry,
   input  logic               queue_full
);

   logic [6:0]  pos_ff,    pos_in;
   logic [23:0] addr_ff,   addr_in;
   logic [7:0]  action_ff, action_in;
   logic [23:0] param_ff,  param_in;
   logic [6:0]  len_ff,    len_in;
   logic        bad_ff,    bad_in;
   logic [23:0] trail_ff,  trail_in;
   logic [7:0]  sum_ff,    sum_in;
   logic [47:0] window_ff, window_in;

   logic        accept;
   logic        in_data;
   logic [7:0]  data_end;
   logic [6:0]  high_digit;

   assign req_stall = queue_full;
   assign accept    = req_valid && !queue_full;

   // Data field bounds for payload pass-through, using the length before this byte.
   assign data_end = {1'b0, atd_pkg::DATA_START} + {1'b0, len_ff};
   assign in_data  = (pos_ff >= atd_pkg::DATA_START) && !bad_ff
                     && (len_ff <= MAX_PAYLOAD)
                     && ({1'b0, pos_ff} < data_end);

   assign high_digit = 7'(atd_pkg::digit_value(req_rx_byte)) * 7'd10;

   // Next value of the field registers for the byte being accepted.
   always_comb begin
      pos_in    = pos_ff;
      addr_in   = addr_ff;
      action_in = action_ff;
      param_in  = param_ff;
      len_in    = len_ff;
      bad_in    = bad_ff;
      sum_in    = sum_ff;
      window_in = window_ff;
      trail_in  = {trail_ff[15:0], req_rx_byte};
      if (pos_ff >= atd_pkg::POS_ACTION) begin
         sum_in = sum_ff + trail_ff[23:16];
      end
      if (pos_ff <= atd_pkg::POS_ADDR_LAST) begin
         addr_in = {addr_ff[15:0], req_rx_byte};
      end else if (pos_ff == atd_pkg::POS_ACTION) begin
         action_in = req_rx_byte;
      end else if (pos_ff >= atd_pkg::POS_PARAM_FIRST && pos_ff <= atd_pkg::POS_PARAM_LAST) begin
         param_in = {param_ff[15:0], req_rx_byte};
      end else if (pos_ff == atd_pkg::POS_LEN_HIGH) begin
         if (atd_pkg::is_digit(req_rx_byte)) begin
            len_in = high_digit;
         end else begin
            bad_in = 1'b1;
            len_in = '0;
         end
      end else if (pos_ff == atd_pkg::POS_LEN_LOW) begin
         if (atd_pkg::is_digit(req_rx_byte) && !bad_ff) begin
            len_in = len_ff + 7'(atd_pkg::digit_value(req_rx_byte));
         end else begin
            bad_in = 1'b1;
            len_in = '0;
         end
      end
      if (pos_ff >= atd_pkg::DATA_START
          && pos_ff < atd_pkg::DATA_START + atd_pkg::WINDOW_LEN) begin
         window_in = {window_ff[39:0], req_rx_byte};
      end
      if (pos_ff < POSITION_LIMIT) begin
         pos_in = pos_ff + 7'd1;
      end
   end

   // Transfer toward the back end: payload bytes and end-of-telegram snapshots.
   always_comb begin
      push_entry.kind            = req_final_byte ? atd_pkg::KIND_STATUS
                                                  : atd_pkg::KIND_PAYLOAD;
      push_entry.data_byte       = req_rx_byte;
      push_entry.index           = pos_ff - atd_pkg::DATA_START;
      push_entry.address         = addr_in;
      push_entry.action          = action_in;
      push_entry.parameter_chars = param_in;
      push_entry.length_value    = len_in;
      push_entry.length_bad      = bad_in;
      push_entry.frame_len       = {1'b0, pos_ff} + 8'd1;
      push_entry.trailing        = trail_in;
      push_entry.sum             = sum_in;
      push_entry.window          = window_in;
   end

   assign push = accept && (req_final_byte || in_data);

   // Field registers; everything returns to zero after the final byte.
   always_ff @(posedge clock) begin
      if (reset || (accept && req_final_byte)) begin
         pos_ff    <= '0;
         addr_ff   <= '0;
         action_ff <= '0;
         param_ff  <= '0;
         len_ff    <= '0;
         bad_ff    <= 1'b0;
         trail_ff  <= '0;
         sum_ff    <= '0;
         window_ff <= '0;
      end else if (accept) begin
         pos_ff    <= pos_in;
         addr_ff   <= addr_in;
         action_ff <= action_in;
         param_ff  <= param_in;
         len_ff    <= len_in;
         bad_ff    <= bad_in;
         trail_ff  <= trail_in;
         sum_ff    <= sum_in;
         window_ff <= window_in;
      end
   end

endmodule

/* rtl/atd_queue.sv */
// Short register queue that decouples the front end from the back end.
// Depends on atd_pkg for the entry type and depth.
module atd_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  atd_pkg::entry_type push_entry,
   output logic               full,
   input  logic               pop,
   output atd_pkg::entry_type head,
   output logic               empty
);

   localparam int PTR_W = (atd_pkg::QUEUE_DEPTH > 1) ? $clog2(atd_pkg::QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(atd_pkg::QUEUE_DEPTH + 1);
   localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(atd_pkg::QUEUE_DEPTH);
   localparam logic [PTR_W-1:0] LAST_PTR  = PTR_W'(atd_pkg::QUEUE_DEPTH - 1);
   localparam logic [PTR_W-1:0] PTR_ONE   = PTR_W'(1);
   localparam logic [CNT_W-1:0] CNT_ONE   = CNT_W'(1);

   atd_pkg::entry_type slot_ff [atd_pkg::QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff,  count_in;

   assign full  = (count_ff == DEPTH_CNT);
   assign empty = (count_ff == '0);
   assign head  = slot_ff[rd_ptr_ff];

   // Pointer and fill-count updates.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + PTR_ONE;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + PTR_ONE;
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_ONE;
      end else if (pop && !push) begin
         count_in = count_ff - CNT_ONE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage needs no reset; the fill count guards it.
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

/* rtl/atd_back.sv */
// Back end of the deframer: turns queued entries into result transfers,
// checking frame length, checksum digits and payload codes. Depends on atd_pkg.
module atd_back #(
   parameter logic [6:0] MAX_PAYLOAD = atd_pkg::MAX_PAYLOAD,
   parameter logic [7:0] MIN_FRAME   = atd_pkg::MIN_FRAME
) (
   input  logic               clock,
   input  logic               reset,
   input  atd_pkg::entry_type head,
   input  logic               empty,
   output logic               pop,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic               rsp_item_kind,
   output logic [7:0]         rsp_payload_byte,
   output logic [6:0]         rsp_payload_index,
   output logic [23:0]        rsp_address_chars,
   output logic [7:0]         rsp_action_char,
   output logic [23:0]        rsp_parameter_chars,
   output logic [6:0]         rsp_declared_length,
   output logic [2:0]         rsp_status,
   output logic [9:0]         rsp_received_sum,
   output logic [7:0]         rsp_computed_sum
);

   logic        valid_ff;
   logic        kind_ff;
   logic [7:0]  byte_ff;
   logic [6:0]  index_ff;
   logic [23:0] addr_ff;
   logic [7:0]  action_ff;
   logic [23:0] param_ff;
   logic [6:0]  len_ff;
   logic [2:0]  status_ff;
   logic [9:0]  rsum_ff;
   logic [7:0]  csum_ff;

   logic        kind_in;
   logic [7:0]  byte_in;
   logic [6:0]  index_in;
   logic [23:0] addr_in;
   logic [7:0]  action_in;
   logic [23:0] param_in;
   logic [6:0]  len_in;
   logic [2:0]  status_in;
   logic [9:0]  rsum_in;
   logic [7:0]  csum_in;

   logic [7:0]  c0, c1, c2;
   logic        digits_ok;
   logic        frame_bad;
   logic [7:0]  expected_len;
   logic [9:0]  rsum_value;

   // The output register loads the queue head while empty or being drained.
   assign pop       = !empty && (!valid_ff || !rsp_stall);
   assign rsp_valid = valid_ff;

   assign c0 = head.trailing[23:16];
   assign c1 = head.trailing[15:8];
   assign c2 = head.trailing[7:0];
   assign digits_ok = atd_pkg::is_digit(c0) && atd_pkg::is_digit(c1)
                      && atd_pkg::is_digit(c2);
   assign expected_len = MIN_FRAME + {1'b0, head.length_value};
   assign frame_bad = head.length_bad || (head.length_value > MAX_PAYLOAD)
                      || (head.frame_len != expected_len) || !digits_ok;
   assign rsum_value = 10'(atd_pkg::digit_value(c0)) * 10'd100
                       + 10'(atd_pkg::digit_value(c1)) * 10'd10
                       + 10'(atd_pkg::digit_value(c2));

   // Result fields for the entry at the head of the queue.
   always_comb begin
      kind_in   = head.kind;
      byte_in   = '0;
      index_in  = '0;
      addr_in   = '0;
      action_in = '0;
      param_in  = '0;
      len_in    = '0;
      status_in = atd_pkg::STATUS_OK;
      rsum_in   = '0;
      csum_in   = '0;
      if (head.kind == atd_pkg::KIND_PAYLOAD) begin
         byte_in  = head.data_byte;
         index_in = head.index;
      end else if (head.frame_len < MIN_FRAME) begin
         status_in = atd_pkg::STATUS_FRAME;
      end else begin
         addr_in   = head.address;
         action_in = head.action;
         param_in  = head.parameter_chars;
         len_in    = head.length_value;
         if (frame_bad) begin
            status_in = atd_pkg::STATUS_FRAME;
         end else begin
            if (head.length_value == atd_pkg::WINDOW_LEN) begin
               unique if (head.window == atd_pkg::CODE_NODEF) begin
                  status_in = atd_pkg::STATUS_NODEF;
               end else if (head.window == atd_pkg::CODE_RANGE) begin
                  status_in = atd_pkg::STATUS_RANGE;
               end else if (head.window == atd_pkg::CODE_LOGIC) begin
                  status_in = atd_pkg::STATUS_LOGIC;
               end else begin
                  status_in = atd_pkg::STATUS_OK;
               end
            end
            rsum_in = rsum_value;
            csum_in = head.sum;
            // A checksum mismatch overrides any payload code.
            if (rsum_value != {2'b00, head.sum}) begin
               status_in = atd_pkg::STATUS_FRAME;
            end
         end
      end
   end

   // Output valid flag.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (!valid_ff || !rsp_stall) begin
         valid_ff <= pop;
      end
   end

   // Output payload register.
   always_ff @(posedge clock) begin
      if (pop) begin
         kind_ff   <= kind_in;
         byte_ff   <= byte_in;
         index_ff  <= index_in;
         addr_ff   <= addr_in;
         action_ff <= action_in;
         param_ff  <= param_in;
         len_ff    <= len_in;
         status_ff <= status_in;
         rsum_ff   <= rsum_in;
         csum_ff   <= csum_in;
      end
   end

   assign rsp_item_kind       = kind_ff;
   assign rsp_payload_byte    = byte_ff;
   assign rsp_payload_index   = index_ff;
   assign rsp_address_chars   = addr_ff;
   assign rsp_action_char     = action_ff;
   assign rsp_parameter_chars = param_ff;
   assign rsp_declared_length = len_ff;
   assign rsp_status          = status_ff;
   assign rsp_received_sum    = rsum_ff;
   assign rsp_computed_sum    = csum_ff;

endmodule

/* rtl/ascii_telegram_deframer.sv */
// Top level of the ASCII telegram deframer: front end, queue and back end.
// Depends on atd_pkg, atd_front, atd_queue and atd_back.
//
//   channel | direction | handshake            | payload
//   req_    | in        | req_valid/req_stall  | rx_byte, final_byte
//   rsp_    | out       | rsp_valid/rsp_stall  | kind, payload byte/index, header, status, sums
//
// One byte is accepted per cycle while req_stall is low; each result is registered in the
// queue and then in the output register. The front end stalls only when the two-entry
// queue is full, which happens only after the result channel has stalled.
// Reset is synchronous and clears the telegram fields, the queue and the
// output valid flag; no clearing pass is needed.
module ascii_telegram_deframer #(
   parameter logic [6:0] MAX_PAYLOAD    = atd_pkg::MAX_PAYLOAD,
   parameter logic [7:0] MIN_FRAME      = atd_pkg::MIN_FRAME,
   parameter logic [6:0] POSITION_LIMIT = atd_pkg::POSITION_LIMIT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_rx_byte,
   input  logic        req_final_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_item_kind,
   output logic [7:0]  rsp_payload_byte,
   output logic [6:0]  rsp_payload_index,
   output logic [23:0] rsp_address_chars,
   output logic [7:0]  rsp_action_char,
   output logic [23:0] rsp_parameter_chars,
   output logic [6:0]  rsp_declared_length,
   output logic [2:0]  rsp_status,
   output logic [9:0]  rsp_received_sum,
   output logic [7:0]  rsp_computed_sum
);

   logic               push;
   atd_pkg::entry_type push_entry;
   logic               queue_full;
   logic               pop;
   atd_pkg::entry_type head;
   logic               empty;

   // Byte classification and field tracking.
   atd_front #(
      .MAX_PAYLOAD    (MAX_PAYLOAD),
      .POSITION_LIMIT (POSITION_LIMIT)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_rx_byte    (req_rx_byte),
      .req_final_byte (req_final_byte),
      .push           (push),
      .push_entry     (push_entry),
      .queue_full     (queue_full)
   );

   // Decoupling queue.
   atd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .full       (queue_full),
      .pop        (pop),
      .head       (head),
      .empty      (empty)
   );

   // Status evaluation and output register.
   atd_back #(
      .MAX_PAYLOAD (MAX_PAYLOAD),
      .MIN_FRAME   (MIN_FRAME)
   ) u_back (
      .clock               (clock),
      .reset               (reset),
      .head                (head),
      .empty               (empty),
      .pop                 (pop),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_item_kind       (rsp_item_kind),
      .rsp_payload_byte    (rsp_payload_byte),
      .rsp_payload_index   (rsp_payload_index),
      .rsp_address_chars   (rsp_address_chars),
      .rsp_action_char     (rsp_action_char),
      .rsp_parameter_chars (rsp_parameter_chars),
      .rsp_declared_length (rsp_declared_length),
      .rsp_status          (rsp_status),
      .rsp_received_sum    (rsp_received_sum),
      .rsp_computed_sum    (rsp_computed_sum)
   );

endmodule
